[rtl/core/flash_controller_register_block_top_assert.svh]
// ----------------------------------------------------------------------------
// Flash controller register block assertion macros
// Shared property forms for the assertions of the register block.
// ----------------------------------------------------------------------------
`ifndef FLASH_CONTROLLER_REGISTER_BLOCK_TOP_ASSERT_SVH
`define FLASH_CONTROLLER_REGISTER_BLOCK_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FCRB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/fcrb_pkg.sv]
// ----------------------------------------------------------------------------
// Flash controller register block package
// Beat types, codes, register offsets and the factory information table.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrb_pkg;

	localparam int USER_WORDS_DEF = 64;
	localparam int FACTORY_WORDS = 64;
	localparam int FACTORY_TABLE_WORDS = 64;

	localparam logic [11:0] OFS_READY        = 12'h400;
	localparam logic [11:0] OFS_CONFIG       = 12'h504;
	localparam logic [11:0] OFS_ERASE_PAGE_A = 12'h508;
	localparam logic [11:0] OFS_ERASE_ALL    = 12'h50C;
	localparam logic [11:0] OFS_ERASE_PAGE_B = 12'h510;
	localparam logic [11:0] OFS_ERASE_USER   = 12'h514;

	localparam logic [31:0] ERASE_KEY = 32'h0000_0001;
	localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} access_t;

	typedef enum logic [1:0] {
		REGION_CTRL    = 2'd0,
		REGION_FACTORY = 2'd1,
		REGION_USER    = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		ERASE_NONE = 2'd0,
		ERASE_PAGE = 2'd1,
		ERASE_ALL  = 2'd2
	} erase_op_t;

	typedef enum logic {
		CFG_PAGE_SIZE_LOG2 = 1'b0,
		CFG_FLASH_PAGES    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS
	} ctl_state_t;

	typedef struct packed {
		access_t     func;
		logic [1:0]  region;
		logic [11:0] byte_offset;
		logic [31:0] write_data;
	} req_beat_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_offset;
		erase_op_t   erase_op;
		logic [26:0] erase_address;
	} rsp_beat_t;

	typedef struct packed {
		cfg_reg_t    index;
		logic [15:0] value;
	} cfg_beat_t;

	function automatic logic [31:0] factory_word(input logic [5:0] idx);
		logic [31:0] w;
		unique case (idx)
			6'd4:    w = 32'h0000_0400;
			6'd5:    w = 32'h0000_0100;
			6'd8:    w = 32'h0000_0002;
			6'd9:    w = 32'h0000_2000;
			6'd10:   w = 32'h0000_2000;
			6'd11:   w = 32'h0000_2000;
			6'd24:   w = 32'h0000_0003;
			6'd25:   w = 32'h1234_5678;
			6'd26:   w = 32'h9ABC_DEF1;
			default: w = ALL_ONES;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/core/fcrb_chan_if.sv]
// ----------------------------------------------------------------------------
// Flash controller register block channel
// Valid and ready handshake carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcrb_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/flash_controller_register_block_top.sv]
// ----------------------------------------------------------------------------
// Flash controller register block
// Bus accesses arrive as req beats (func, region, byte_offset, write_data)
// and each gives exactly one rsp beat (read_data, bad_offset, erase_op,
// erase_address). Configuration beats on cfg write page_size_log2 (index 0)
// and flash_pages (index 1); cfg is always ready.
// The user store is a synchronous memory, read in the cycle of acceptance;
// the access is evaluated, and written back, in the access state, which
// holds while the output register is full. One access is in flight at a
// time: a new one is taken only when the last has left the access state.
// The result sits in an output register; a new access is taken while it
// waits, and only its own completion waits for rsp to drain.
// After reset, and after an erase-all or erase-user command, the user store
// is swept to all ones, one word a cycle, through all USER_WORDS words,
// during which req is not ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flash_controller_register_block_top_assert.svh"

module flash_controller_register_block_top
	import fcrb_pkg::*;
#(
	parameter int USER_WORDS = USER_WORDS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	fcrb_chan_if.sink      req,
	fcrb_chan_if.source    rsp,
	fcrb_chan_if.sink      cfg
);

	localparam int UIDX_W = (USER_WORDS > 1) ? $clog2(USER_WORDS) : 1;

	ctl_state_t        state_q, state_d;
	logic [3:0]        psl_q;
	logic [12:0]       pages_q;
	logic [1:0]        mode_q;
	req_beat_t         req_q;
	logic [31:0]       rdata_q;
	rsp_beat_t         out_q;
	logic              out_valid_q;
	logic [UIDX_W-1:0] clr_idx_q;

	logic [31:0]       user_mem [USER_WORDS];

	logic              accept;
	logic              fire;
	rsp_beat_t         res;
	logic              mode_we;
	logic              user_we;
	logic              start_clear;
	logic              mem_we;
	logic [UIDX_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata;
	logic [9:0]        word;
	logic [31:0]       aligned;
	logic [27:0]       limit;
	logic              page_ok;
	logic              user_in_range;
	logic              fac_in_range;

	assign accept = req.valid && req.ready;
	assign fire   = (state_q == ST_ACCESS) && (!out_valid_q || rsp.ready);

	assign word          = req_q.byte_offset[11:2];
	assign user_in_range = {1'b0, word} < 11'(USER_WORDS);
	assign fac_in_range  = {1'b0, word} < 11'(FACTORY_WORDS);
	assign aligned       = req_q.write_data & (ALL_ONES << psl_q);
	assign limit         = {15'b0, pages_q} << psl_q;
	assign page_ok       = (aligned < {4'b0, limit}) && (aligned[31:27] == 5'b0);

	always_comb begin
		res         = '0;
		mode_we     = 1'b0;
		user_we     = 1'b0;
		start_clear = 1'b0;
		unique case (region_t'(req_q.region))
			REGION_CTRL: begin
				if (req_q.func == ACC_READ) begin
					unique case (req_q.byte_offset)
						OFS_READY:  res.read_data = 32'd1;
						OFS_CONFIG: res.read_data = {30'b0, mode_q};
						default:    res.bad_offset = 1'b1;
					endcase
				end else begin
					unique case (req_q.byte_offset)
						OFS_CONFIG: mode_we = 1'b1;
						OFS_ERASE_PAGE_A, OFS_ERASE_PAGE_B: begin
							if (page_ok) begin
								res.erase_op      = ERASE_PAGE;
								res.erase_address = aligned[26:0];
							end
						end
						OFS_ERASE_ALL: begin
							if (req_q.write_data == ERASE_KEY) begin
								res.erase_op = ERASE_ALL;
								start_clear  = 1'b1;
							end
						end
						OFS_ERASE_USER: start_clear = (req_q.write_data == ERASE_KEY);
						default:        res.bad_offset = 1'b1;
					endcase
				end
			end
			REGION_FACTORY: begin
				if (!fac_in_range) begin
					res.bad_offset = 1'b1;
				end else if (req_q.func == ACC_READ) begin
					res.read_data = ({1'b0, word} < 11'(FACTORY_TABLE_WORDS)) ?
						factory_word(word[5:0]) : ALL_ONES;
				end
			end
			REGION_USER: begin
				if (!user_in_range) begin
					res.bad_offset = 1'b1;
				end else if (req_q.func == ACC_WRITE) begin
					user_we = 1'b1;
				end else begin
					res.read_data = rdata_q;
				end
			end
			default: res.bad_offset = 1'b1;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = word[UIDX_W-1:0];
		mem_wdata = req_q.write_data;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = ALL_ONES;
				if (clr_idx_q == UIDX_W'(USER_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (fire) begin
					mem_we  = user_we;
					state_d = start_clear ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psl_q       <= 4'd10;
			pages_q     <= 13'd256;
			mode_q      <= 2'b0;
			out_valid_q <= 1'b0;
			clr_idx_q   <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.data.index)
					CFG_PAGE_SIZE_LOG2: psl_q   <= cfg.data.value[3:0];
					CFG_FLASH_PAGES:    pages_q <= cfg.data.value[12:0];
				endcase
			end
			if (fire && mode_we) begin
				mode_q <= req_q.write_data[1:0];
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end else begin
				clr_idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			user_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rdata_q <= user_mem[req.data.byte_offset[UIDX_W+1:2]];
		end
	end

	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	`FCRB_ASSERT_NOW(a_no_accept_in_clear, state_q == ST_CLEAR, !req.ready,
		"Request accepted during the user store sweep")
	`FCRB_ASSERT_NEXT(a_accept_to_access, accept, state_q == ST_ACCESS,
		"Accepted request did not move to the access cycle")
	`FCRB_ASSERT_NEXT(a_stall_holds_access, (state_q == ST_ACCESS) && out_valid_q && !rsp.ready,
		(state_q == ST_ACCESS) && $stable(req_q),
		"Pending access lost while the output register was full")
	`FCRB_ASSERT_NEXT(a_erase_all_clears, fire && (res.erase_op == ERASE_ALL),
		state_q == ST_CLEAR, "Erase-all did not start the user store sweep")

endmodule

`default_nettype wire
